// File: rtl/core/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg: shared types and constants of the feedback queue scheduler
// Command and status codes, level count and quantum reset values.
// ----------------------------------------------------------------------------
`default_nettype none
package mlfq_pkg;
    localparam int unsigned DefQueueDepth = 64;
    localparam int unsigned NumLevels     = 3;

    localparam logic [7:0] QuantumHighReset = 8'd2;
    localparam logic [7:0] QuantumMedReset  = 8'd4;
    localparam logic [7:0] QuantumLowReset  = 8'd8;

    typedef enum logic [1:0] {
        CFG_Q_HIGH = 2'd0,
        CFG_Q_MED  = 2'd1,
        CFG_Q_LOW  = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_ADD = 1'b0,
        CMD_RUN = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_ADDED   = 2'd0,
        ST_RAN     = 2'd1,
        ST_IDLE    = 2'd2,
        ST_REFUSED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } t_bk_state;

    // Item passed from the front stage to the back stage.
    typedef struct packed {
        logic        cmd;
        logic [7:0]  pid;
        logic [15:0] dur;
    } t_cmd_item;

    // Result item.
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  ran_id;
        logic [1:0]  level;
        logic [7:0]  slice_length;
        logic [15:0] time_left;
        logic        finished;
        logic [31:0] clock_now;
    } t_result;
endpackage
`default_nettype wire

// File: rtl/core/mlfq_front.sv
// ----------------------------------------------------------------------------
// mlfq_front: input stage
// Registers one command item and hands it on to the back stage.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_front
    import mlfq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_process_id,
    input  wire logic [15:0] i_duration,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output t_cmd_item        o_cmd
);
    logic      r_valid;
    t_cmd_item r_item;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= '{cmd: i_command, pid: i_process_id, dur: i_duration};
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/mlfq_back.sv
// ----------------------------------------------------------------------------
// mlfq_back: queue memory and scheduling engine
// Holds the three level FIFOs in one memory, executes add and run commands.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_back
    import mlfq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    output logic            o_cmd_ready,
    input  wire t_cmd_item  i_cmd,
    input  wire logic [7:0] i_q_high,
    input  wire logic [7:0] i_q_med,
    input  wire logic [7:0] i_q_low,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output t_result         o_res
);
    localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MemD = NumLevels * QUEUE_DEPTH;
    localparam int unsigned AddrW = $clog2(MemD);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

    logic [23:0] r_mem [MemD];
    logic [23:0] r_rd_data;

    logic [PtrW-1:0] r_head [NumLevels];
    logic [PtrW-1:0] r_tail [NumLevels];
    logic [CntW-1:0] r_count [NumLevels];
    logic [CntW-1:0] r_total;
    logic [31:0]     r_clock;

    t_bk_state r_state, n_state;
    logic [1:0] r_lv;
    logic       r_res_valid;
    t_result    r_res;

    logic       rd_en;
    logic [AddrW-1:0] rd_addr, wr_addr;
    logic       wr_en;
    logic [23:0] wr_data;
    logic [1:0] sel_lv, dst_lv;
    logic       any_held;
    logic [7:0] quantum;
    logic [15:0] run_len, rest;
    logic       out_free;
    logic       res_load;

    function automatic logic [AddrW-1:0] addr_of(logic [1:0] lv, logic [PtrW-1:0] p);
        return AddrW'(lv) * AddrW'(QUEUE_DEPTH) + AddrW'(p);
    endfunction

    function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
        return (p == LastPtr) ? '0 : p + PtrW'(1);
    endfunction

    assign out_free    = !r_res_valid || i_res_ready;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // A new result is loaded for an add, an idle run, or an executed slice.
    assign res_load = (r_state == BK_IDLE && o_cmd_ready &&
                       (i_cmd.cmd == CMD_ADD || !any_held)) ||
                      (r_state == BK_EXEC && out_free);

    always_comb begin
        any_held = 1'b1;
        sel_lv   = 2'd0;
        priority if (r_count[0] != '0) sel_lv = 2'd0;
        else if (r_count[1] != '0)     sel_lv = 2'd1;
        else if (r_count[2] != '0)     sel_lv = 2'd2;
        else                           any_held = 1'b0;
    end

    always_comb begin
        unique case (r_lv)
            2'd0:    quantum = i_q_high;
            2'd1:    quantum = i_q_med;
            default: quantum = i_q_low;
        endcase
        run_len = (r_rd_data[15:0] < {8'd0, quantum}) ? r_rd_data[15:0] : {8'd0, quantum};
        rest    = r_rd_data[15:0] - run_len;
        dst_lv  = (r_lv == 2'd0) ? 2'd1 : 2'd2;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = addr_of(sel_lv, r_head[sel_lv]);
        wr_en       = 1'b0;
        wr_addr     = addr_of(2'd0, r_tail[0]);
        wr_data     = {i_cmd.pid, i_cmd.dur};
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_ready = 1'b1;
                    if (i_cmd.cmd == CMD_ADD) begin
                        wr_en = (r_total != FullCnt);
                    end else if (any_held) begin
                        rd_en   = 1'b1;
                        n_state = BK_READ;
                    end
                end
            end
            BK_READ: n_state = BK_EXEC;
            BK_EXEC: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                    wr_en   = (rest != 16'd0);
                    wr_addr = addr_of(dst_lv, r_tail[dst_lv]);
                    wr_data = {r_rd_data[23:16], rest};
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_res_valid <= 1'b0;
            r_total     <= '0;
            r_clock     <= '0;
            r_lv        <= '0;
            for (int i = 0; i < NumLevels; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_res_valid <= res_load || (r_res_valid && !i_res_ready);
            if (r_state == BK_IDLE && o_cmd_ready) begin
                if (i_cmd.cmd == CMD_ADD) begin
                    r_res <= '{status: (wr_en ? ST_ADDED : ST_REFUSED), ran_id: '0,
                               level: '0, slice_length: '0, time_left: '0,
                               finished: 1'b0, clock_now: r_clock};
                    if (wr_en) begin
                        r_tail[0]  <= bump(r_tail[0]);
                        r_count[0] <= r_count[0] + CntW'(1);
                        r_total    <= r_total + CntW'(1);
                    end
                end else if (!any_held) begin
                    r_res <= '{status: ST_IDLE, ran_id: '0, level: '0, slice_length: '0,
                               time_left: '0, finished: 1'b0, clock_now: r_clock};
                end else begin
                    r_lv <= sel_lv;
                    r_head[sel_lv]  <= bump(r_head[sel_lv]);
                    r_count[sel_lv] <= r_count[sel_lv] - CntW'(1);
                end
            end
            if (r_state == BK_EXEC && out_free) begin
                r_clock     <= r_clock + 32'(run_len);
                r_res <= '{status: ST_RAN, ran_id: r_rd_data[23:16], level: r_lv,
                           slice_length: run_len[7:0], time_left: rest,
                           finished: (rest == 16'd0), clock_now: r_clock + 32'(run_len)};
                if (rest == 16'd0) begin
                    r_total <= r_total - CntW'(1);
                end else begin
                    r_tail[dst_lv]  <= bump(r_tail[dst_lv]);
                    r_count[dst_lv] <= r_count[dst_lv] + CntW'(1);
                end
            end
        end
    end

`ifndef SYNTH
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= FullCnt) else $error("held count exceeds depth");
    a_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE) |->
        (32'(r_count[0]) + 32'(r_count[1]) + 32'(r_count[2]) == 32'(r_total)))
        else $error("level counts disagree with held count");
    a_read_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_READ) |=> (r_state == BK_EXEC)) else $error("read not followed");
`endif
endmodule
`default_nettype wire

// File: rtl/core/multilevel_feedback_queue_scheduler.sv
// A three-level feedback queue scheduler. An add item (command 0) places a
// process at the tail of the top level, or is refused with status 3 once
// QUEUE_DEPTH processes are held. A run item (command 1) takes the head of
// the highest non-empty level, runs it for the smaller of its remaining time
// and that level's quantum, advances a wrapping 32-bit clock and returns the
// slice; unfinished processes drop one level, the lowest requeues into itself.
// An add or an idle run ends in the back idle state; an executed run goes
// through the idle, read and execute states, for the registered read of the shared
// queue memory and the write-back of the demoted entry. The front register
// accepts the next item while the back stage works, and the result register
// holds a finished item until taken. The user writes quantum registers via the
// plain configuration port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
// multilevel_feedback_queue_scheduler: top level
// Configuration registers, front input stage and back scheduling engine.
// ----------------------------------------------------------------------------
`default_nettype none
module multilevel_feedback_queue_scheduler
    import mlfq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = DefQueueDepth
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_command,
    input  wire logic [7:0]  i_process_id,
    input  wire logic [15:0] i_duration,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [7:0]       o_ran_id,
    output logic [1:0]       o_level,
    output logic [7:0]       o_slice_length,
    output logic [15:0]      o_time_left,
    output logic             o_finished,
    output logic [31:0]      o_clock_now
);
    logic [7:0] r_q_high, r_q_med, r_q_low;
    logic       cmd_valid, cmd_ready;
    t_cmd_item  cmd;
    t_result    res;

    // Quantum registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_high <= QuantumHighReset;
            r_q_med  <= QuantumMedReset;
            r_q_low  <= QuantumLowReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_Q_HIGH: r_q_high <= i_cfg_data;
                CFG_Q_MED:  r_q_med  <= i_cfg_data;
                CFG_Q_LOW:  r_q_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mlfq_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_command, .i_process_id,
        .i_duration, .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .o_cmd(cmd)
    );

    mlfq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_cmd(cmd), .i_q_high(r_q_high), .i_q_med(r_q_med), .i_q_low(r_q_low),
        .o_res_valid(o_valid), .i_res_ready(i_ready), .o_res(res)
    );

    assign o_status       = res.status;
    assign o_ran_id       = res.ran_id;
    assign o_level        = res.level;
    assign o_slice_length = res.slice_length;
    assign o_time_left    = res.time_left;
    assign o_finished     = res.finished;
    assign o_clock_now    = res.clock_now;
endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the feedback queue scheduler
// Drives add and run items over valid/ready with random idling, predicts each
// result with an in-bench model of the three levels and compares the whole result.
// ----------------------------------------------------------------------------
module tb;
    import mlfq_pkg::*;

    localparam int unsigned Depth = DefQueueDepth;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_command;
    logic [7:0]  i_process_id;
    logic [15:0] i_duration;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_status;
    logic [7:0]  o_ran_id;
    logic [1:0]  o_level;
    logic [7:0]  o_slice_length;
    logic [15:0] o_time_left;
    logic        o_finished;
    logic [31:0] o_clock_now;

    multilevel_feedback_queue_scheduler #(.QUEUE_DEPTH(Depth)) DUT (.*);

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // A queued process: its id and the run time it still needs.
    typedef struct {
        logic [7:0]  pid;
        logic [15:0] left;
    } proc_t;

    // Predictor state: one FIFO per level, quanta, process count and clock.
    proc_t       sched_levels[NumLevels][$];
    logic [7:0]  quanta[NumLevels];
    int unsigned procs_held;
    logic [31:0] sim_clock;

    t_result     expected_slices[$];
    int          errors;
    bit          rx_hold;
    bit          no_idle;

    function automatic t_result schedule_item(t_cmd cmd, logic [7:0] pid,
                                              logic [15:0] dur);
        t_result r;
        proc_t   p;
        int      lv;
        logic [15:0] run;
        r = '0;
        if (cmd == CMD_ADD) begin
            if (procs_held >= Depth) begin
                r.status = ST_REFUSED;
            end else begin
                sched_levels[0].push_back('{pid, dur});
                procs_held++;
                r.status = ST_ADDED;
            end
            r.clock_now = sim_clock;
            return r;
        end
        lv = 0;
        while (lv < NumLevels && sched_levels[lv].size() == 0) lv++;
        if (lv == NumLevels) begin
            r.status    = ST_IDLE;
            r.clock_now = sim_clock;
            return r;
        end
        p   = sched_levels[lv].pop_front();
        run = (p.left < quanta[lv]) ? p.left : 16'(quanta[lv]);
        sim_clock += 32'(run);
        r.status       = ST_RAN;
        r.ran_id       = p.pid;
        r.level        = 2'(lv);
        r.slice_length = run[7:0];
        r.time_left    = p.left - run;
        r.finished     = (r.time_left == 0);
        r.clock_now    = sim_clock;
        if (r.finished) begin
            procs_held--;
        end else begin
            sched_levels[(lv < NumLevels - 1) ? lv + 1 : NumLevels - 1]
                .push_back('{p.pid, r.time_left});
        end
        return r;
    endfunction

    // Drives one item, waits for acceptance and queues its expected result.
    // Valid stays high after acceptance only until the next item or an idle
    // cycle replaces it in the same time step.
    task automatic send_item(t_cmd cmd, logic [7:0] pid, logic [15:0] dur);
        while (!no_idle && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_command    <= cmd;
        i_process_id <= pid;
        i_duration   <= dur;
        do @(posedge i_clk); while (!o_ready);
        expected_slices.push_back(schedule_item(cmd, pid, dur));
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (expected_slices.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_quantum(t_cfg_idx idx, logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        quanta[idx] = val;
        @(posedge i_clk);
    endtask

    // Receiver: random stalls, plus a long hold-off when rx_hold is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_ready <= 1'b0;
        else i_ready <= !rx_hold && (no_idle || $urandom_range(99) >= 31);
    end

    // Result checker, sampled at the edge where the handshake completes.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_status, o_ran_id, o_level, o_slice_length, o_time_left,
                    o_finished, o_clock_now};
            if (expected_slices.size() == 0) begin
                $display("%0t unexpected item: actual %p", $time, got);
                errors++;
            end else begin
                want = expected_slices.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // Directed table: command, id, duration, whether the status is known at a
    // glance (after reset, idle run, extremes) and that expected status.
    typedef struct {
        t_cmd        cmd;
        logic [7:0]  pid;
        logic [15:0] dur;
        bit          known;
        t_status     st;
    } dir_row_t;

    dir_row_t directed[] = '{
        '{CMD_RUN, 8'h00, 16'h0000, 1, ST_IDLE},
        '{CMD_ADD, 8'h00, 16'h0000, 1, ST_ADDED},
        '{CMD_ADD, 8'hFF, 16'hFFFF, 1, ST_ADDED},
        '{CMD_ADD, 8'hA5, 16'h0003, 1, ST_ADDED},
        '{CMD_ADD, 8'h5A, 16'h0001, 1, ST_ADDED},
        '{CMD_RUN, 8'hFF, 16'hFFFF, 0, ST_RAN},
        '{CMD_RUN, 8'h00, 16'h0000, 0, ST_RAN},
        '{CMD_RUN, 8'h00, 16'h0000, 0, ST_RAN},
        '{CMD_RUN, 8'h00, 16'h0000, 0, ST_RAN},
        '{CMD_RUN, 8'h00, 16'h0000, 0, ST_RAN},
        '{CMD_RUN, 8'h00, 16'h0000, 0, ST_RAN},
        '{CMD_RUN, 8'h00, 16'h0000, 0, ST_RAN},
        '{CMD_RUN, 8'h00, 16'h0000, 0, ST_RAN}
    };

    initial begin
        t_result pend;
        int      n;
        errors = 0; rx_hold = 0; no_idle = 0;
        procs_held = 0; sim_clock = 0;
        quanta[0] = QuantumHighReset;
        quanta[1] = QuantumMedReset;
        quanta[2] = QuantumLowReset;
        i_rst_n <= 1'b0; i_cfg_we <= 1'b0; i_cfg_index <= CFG_Q_HIGH;
        i_cfg_data <= '0; i_valid <= 1'b0; i_command <= CMD_ADD;
        i_process_id <= '0; i_duration <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            send_item(directed[k].cmd, directed[k].pid, directed[k].dur);
            pend = expected_slices[$];
            if (directed[k].known && pend.status != directed[k].st) begin
                $display("%0t table row %0d: expected %0d actual %0d", $time, k,
                         directed[k].st, pend.status);
                errors++;
            end
        end
        drain();

        // Zero quanta everywhere, then the maximum, then random phases.
        write_quantum(CFG_Q_HIGH, 8'd0);
        write_quantum(CFG_Q_MED, 8'd0);
        write_quantum(CFG_Q_LOW, 8'd0);
        send_item(CMD_ADD, 8'h11, 16'd5);
        repeat (4) send_item(CMD_RUN, 8'h00, 16'h0000);
        drain();
        write_quantum(CFG_Q_HIGH, 8'd255);
        write_quantum(CFG_Q_MED, 8'd255);
        write_quantum(CFG_Q_LOW, 8'd255);
        repeat (3) send_item(CMD_RUN, 8'h00, 16'h0000);

        // Fill past capacity while the receiver holds off, to hit refusals.
        drain();
        rx_hold = 1;
        fork
            begin
                repeat (Depth + 4) send_item(CMD_ADD, 8'($urandom), 16'($urandom));
                i_valid <= 1'b0;
            end
            begin
                repeat (300) @(posedge i_clk);
                rx_hold = 0;
            end
        join
        drain();
        // Issue run items in a stretch with no idling.
        no_idle = 1;
        repeat (80) send_item(CMD_RUN, 8'h00, 16'h0000);
        no_idle = 0;
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            write_quantum(CFG_Q_HIGH, 8'($urandom_range(255, 1)));
            write_quantum(CFG_Q_MED, 8'($urandom_range(255, 1)));
            write_quantum(CFG_Q_LOW, (phase == 5) ? 8'd1 : 8'($urandom));
            no_idle = (phase == 3);
            for (n = 0; n < 200; n++) begin
                if ($urandom_range(99) < 45)
                    send_item(CMD_ADD, 8'($urandom),
                              ($urandom_range(9) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(40)));
                else
                    send_item(CMD_RUN, 8'($urandom), 16'($urandom));
            end
            no_idle = 0;
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: multilevel_feedback_queue_scheduler.f
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_front.sv
rtl/core/mlfq_back.sv
rtl/core/multilevel_feedback_queue_scheduler.sv
test/tb.sv
